FILE: rtl/chacha20_stream_cipher_top_macros.svh
// Assertion macros used by the checker file.
`ifndef CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/chacha_pkg.sv
`timescale 1ns / 1ps
package chacha_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
    localparam int RND_W         = $clog2(ROUNDS);
    localparam int WORDS         = 16;
    localparam int POS_W         = 4;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY01    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY23    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY45    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY67    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE01  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR = 3'd6;

    // Quarter-round step codes: add/xor/rotate by 16, 12, 8 and 7.
    localparam logic [1:0] STEP_R16 = 2'd0;
    localparam logic [1:0] STEP_R12 = 2'd1;
    localparam logic [1:0] STEP_R8  = 2'd2;
    localparam logic [1:0] STEP_R7  = 2'd3;

    typedef logic [WORDS-1:0][31:0] block_t;
    typedef logic [3:0][63:0]       key_t;

    typedef struct packed {
        logic        start;
        logic [31:0] counter;
    } core_req_t;

    function automatic block_t build_init(key_t key, logic [63:0] n01, logic [31:0] n2,
                                          logic [31:0] ctr);
        block_t b;
        b[0] = SIGMA0;
        b[1] = SIGMA1;
        b[2] = SIGMA2;
        b[3] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            b[4'(4 + 2 * i)] = key[2'(i)][31:0];
            b[4'(5 + 2 * i)] = key[2'(i)][63:32];
        end
        b[12] = ctr;
        b[13] = n01[31:0];
        b[14] = n01[63:32];
        b[15] = n2;
        return b;
    endfunction

    function automatic logic [31:0] byte_mask(logic [2:0] nb);
        logic [31:0] m;
        unique case (nb)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/chacha_qstep.sv
`timescale 1ns / 1ps
module chacha_qstep (
    input  logic [31:0] p_in,
    input  logic [31:0] q_in,
    input  logic [31:0] r_in,
    input  logic [1:0]  step,
    output logic [31:0] p_out,
    output logic [31:0] r_out
);
    import chacha_pkg::*;

    logic [31:0] mix;

    // One quarter-round step: p += q; r = rotl(r ^ p, s).
    assign p_out = p_in + q_in;
    assign mix   = r_in ^ p_out;

    always_comb begin
        unique case (step)
            STEP_R16: r_out = {mix[15:0], mix[31:16]};
            STEP_R12: r_out = {mix[19:0], mix[31:20]};
            STEP_R8:  r_out = {mix[23:0], mix[31:24]};
            STEP_R7:  r_out = {mix[24:0], mix[31:25]};
            default:  r_out = mix;
        endcase
    end

endmodule

FILE: rtl/chacha_core.sv
`timescale 1ns / 1ps
module chacha_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  chacha_pkg::key_t      cfg_key,
    input  logic [63:0]           cfg_nonce01,
    input  logic [31:0]           cfg_nonce2,
    input  chacha_pkg::core_req_t req,
    output logic                  done,
    output chacha_pkg::block_t    ks
);
    import chacha_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ROUND = 2'd1;
    localparam logic [1:0] PH_ADD   = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [1:0]       stp_reg, stp_next;
    logic [31:0]      ctr_reg, ctr_next;
    logic             done_reg, done_next;
    block_t           state_reg, state_next;
    block_t           init_start, init_add;

    logic [31:0] lane_p [4];
    logic [31:0] lane_q [4];
    logic [31:0] lane_r [4];
    logic [31:0] lane_po [4];
    logic [31:0] lane_ro [4];

    logic diag;
    logic odd_step;

    assign diag     = rnd_reg[0];
    assign odd_step = stp_reg[0];

    assign init_start = build_init(cfg_key, cfg_nonce01, cfg_nonce2, req.counter);
    assign init_add   = build_init(cfg_key, cfg_nonce01, cfg_nonce2, ctr_reg);

    // Operand selection: column rounds use rows as they are, diagonal rounds
    // take rows one, two and three rotated by one, two and three words.
    always_comb begin
        logic [31:0] wa, wb, wc, wd;
        for (int l = 0; l < 4; l++) begin
            wa = state_reg[4'(l)];
            wb = diag ? state_reg[4'(4 + ((l + 1) % 4))] : state_reg[4'(4 + l)];
            wc = diag ? state_reg[4'(8 + ((l + 2) % 4))] : state_reg[4'(8 + l)];
            wd = diag ? state_reg[4'(12 + ((l + 3) % 4))] : state_reg[4'(12 + l)];
            lane_p[l] = odd_step ? wc : wa;
            lane_q[l] = odd_step ? wd : wb;
            lane_r[l] = odd_step ? wb : wd;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        chacha_qstep u_qstep (
            .p_in  (lane_p[g]),
            .q_in  (lane_q[g]),
            .r_in  (lane_r[g]),
            .step  (stp_reg),
            .p_out (lane_po[g]),
            .r_out (lane_ro[g])
        );
    end

    always_comb begin
        phase_next = phase_reg;
        rnd_next   = rnd_reg;
        stp_next   = stp_reg;
        ctr_next   = ctr_reg;
        done_next  = 1'b0;
        state_next = state_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (req.start) begin
                    state_next = init_start;
                    ctr_next   = req.counter;
                    rnd_next   = '0;
                    stp_next   = STEP_R16;
                    phase_next = PH_ROUND;
                end
            end
            PH_ROUND: begin
                for (int l = 0; l < 4; l++) begin
                    if (!odd_step) begin
                        state_next[4'(l)] = lane_po[l];
                        if (diag) begin
                            state_next[4'(12 + ((l + 3) % 4))] = lane_ro[l];
                        end else begin
                            state_next[4'(12 + l)] = lane_ro[l];
                        end
                    end else begin
                        if (diag) begin
                            state_next[4'(8 + ((l + 2) % 4))] = lane_po[l];
                            state_next[4'(4 + ((l + 1) % 4))] = lane_ro[l];
                        end else begin
                            state_next[4'(8 + l)] = lane_po[l];
                            state_next[4'(4 + l)] = lane_ro[l];
                        end
                    end
                end
                stp_next = stp_reg + 2'd1;
                if (stp_reg == STEP_R7) begin
                    rnd_next = rnd_reg + RND_W'(1);
                    if (rnd_reg == RND_W'(ROUNDS - 1)) begin
                        phase_next = PH_ADD;
                    end
                end
            end
            PH_ADD: begin
                for (int i = 0; i < WORDS; i++) begin
                    state_next[4'(i)] = state_reg[4'(i)] + init_add[4'(i)];
                end
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            rnd_reg   <= '0;
            stp_reg   <= STEP_R16;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            rnd_reg   <= rnd_next;
            stp_reg   <= stp_next;
            done_reg  <= done_next;
        end
        ctr_reg   <= ctr_next;
        state_reg <= state_next;
    end

    assign done = done_reg;
    assign ks   = state_reg;

endmodule

FILE: rtl/chacha20_stream_cipher_top.sv
`timescale 1ns / 1ps
// ChaCha20 stream cipher, one 32-bit word per handshake.
// Load the key, nonce and initial block counter through the cfg_we / cfg_index /
// cfg_wdata port while no word is in flight. Plaintext words enter on the s_
// channel with a valid byte count and a last-word flag; ciphertext words leave
// on the m_ channel in the same order, one for each input word.
// The first word of every 16-word block starts a keystream block: four
// quarter-round lanes work one add/xor/rotate step per cycle, so each of the
// 20 rounds takes four steps, and a final add of the input block follows them.
// The other 15 words of a block are accepted and then loaded into the output
// register without waiting for the core.
// The counter wraps modulo 2^32 and is reloaded from the configuration after
// a word marked last. Bytes beyond the valid count come out as zero.
// Reset (aresetn low, synchronous) clears the message state, empties the
// output register and restores the configuration defaults (counter one).
// When the receiver stalls, the finished word waits in the output register;
// one further input word can still be accepted and is held until the output
// register frees up.
module chacha20_stream_cipher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_plain_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_cipher_word,
    output logic [2:0]  m_valid_bytes_out,
    output logic        m_last_out
);
    import chacha_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WAIT = 1'b1;

    // Configuration registers.
    key_t        key_reg;
    logic [63:0] nonce01_reg;
    logic [31:0] nonce2_reg;
    logic [31:0] init_ctr_reg;

    // Message bookkeeping.
    logic             state_reg, state_next;
    logic             active_reg, active_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      blk_ctr_reg, blk_ctr_next;
    logic             need_blk_reg, need_blk_next;

    // The accepted word, held until its keystream word is ready.
    logic [31:0]      hold_word_reg;
    logic [2:0]       hold_nb_reg;
    logic             hold_last_reg;
    logic [POS_W-1:0] hold_pos_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg;
    logic [2:0]  out_nb_reg;
    logic        out_last_reg;

    logic             accept;
    logic             produce;
    logic [POS_W-1:0] pos_eff;
    logic [31:0]      ctr_eff;
    core_req_t        core_req;
    logic             core_done;
    block_t           ks;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // A word outside a message starts a new one at position zero with the
    // counter taken from the configuration.
    assign pos_eff = active_reg ? pos_reg : '0;
    assign ctr_eff = active_reg ? blk_ctr_reg : init_ctr_reg;

    assign core_req.start   = accept && (pos_eff == '0);
    assign core_req.counter = ctr_eff;

    chacha_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_key     (key_reg),
        .cfg_nonce01 (nonce01_reg),
        .cfg_nonce2  (nonce2_reg),
        .req         (core_req),
        .done        (core_done),
        .ks          (ks)
    );

    assign produce = (state_reg == ST_WAIT) && !need_blk_reg && (!out_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        active_next   = active_reg;
        pos_next      = pos_reg;
        blk_ctr_next  = blk_ctr_reg;
        need_blk_next = need_blk_reg;
        if (core_done) begin
            need_blk_next = 1'b0;
        end
        if (accept) begin
            state_next    = ST_WAIT;
            need_blk_next = (pos_eff == '0);
            blk_ctr_next  = (pos_eff == '0) ? ctr_eff + 32'd1 : ctr_eff;
            if (s_last_word) begin
                active_next = 1'b0;
                pos_next    = '0;
            end else begin
                active_next = 1'b1;
                pos_next    = pos_eff + POS_W'(1);
            end
        end else if (produce) begin
            state_next = ST_IDLE;
        end
        out_valid_next = out_valid_reg;
        if (produce) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg       <= '0;
            nonce01_reg   <= '0;
            nonce2_reg    <= '0;
            init_ctr_reg  <= 32'd1;
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            blk_ctr_reg   <= '0;
            need_blk_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_KEY01:    key_reg[0]   <= cfg_wdata;
                    CFG_KEY23:    key_reg[1]   <= cfg_wdata;
                    CFG_KEY45:    key_reg[2]   <= cfg_wdata;
                    CFG_KEY67:    key_reg[3]   <= cfg_wdata;
                    CFG_NONCE01:  nonce01_reg  <= cfg_wdata;
                    CFG_NONCE2:   nonce2_reg   <= cfg_wdata[31:0];
                    CFG_INIT_CTR: init_ctr_reg <= cfg_wdata[31:0];
                    default: begin
                    end
                endcase
            end
            state_reg     <= state_next;
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            blk_ctr_reg   <= blk_ctr_next;
            need_blk_reg  <= need_blk_next;
            out_valid_reg <= out_valid_next;
        end
        if (accept) begin
            hold_word_reg <= s_plain_word;
            hold_nb_reg   <= s_valid_bytes;
            hold_last_reg <= s_last_word;
            hold_pos_reg  <= pos_eff;
        end
        if (produce) begin
            out_word_reg <= (hold_word_reg ^ ks[hold_pos_reg]) & byte_mask(hold_nb_reg);
            out_nb_reg   <= hold_nb_reg;
            out_last_reg <= hold_last_reg;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_cipher_word     = out_word_reg;
    assign m_valid_bytes_out = out_nb_reg;
    assign m_last_out        = out_last_reg;

endmodule

FILE: rtl/chacha_checker.sv
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_top_macros.svh"
module chacha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_cipher_word,
    input logic [2:0]  m_valid_bytes_out
);

    // A stalled result holds its word.
    `CHK_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_cipher_word))

    // The block works on one word at a time.
    `CHK_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

    // Bytes past a count of one come out as zero.
    `CHK_IMPLY(a_mask_one, aclk, aresetn, m_valid && (m_valid_bytes_out == 3'd1),
               m_cipher_word[31:8] == 24'd0)

    // Reset empties the output register.
    `CHK_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)

endmodule

bind chacha20_stream_cipher_top chacha_checker u_chacha_checker (.*);
